/* hdl/char_lcd_command_sequencer_top_defines.svh */
// Assertion macros for the character-LCD command sequencer.
`ifndef CHAR_LCD_COMMAND_SEQUENCER_TOP_DEFINES_SVH
`define CHAR_LCD_COMMAND_SEQUENCER_TOP_DEFINES_SVH

// Same-cycle implication, masked while reset is asserted.
`define CLCS_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, masked while reset is asserted.
`define CLCS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/clcs_pkg.sv */
// Types, constants and the operation table of the character-LCD command sequencer.
package clcs_pkg;

  typedef enum logic [1:0] {
    ACT_INIT  = 2'd0,
    ACT_WRITE = 2'd1,
    ACT_SHUT  = 2'd2,
    ACT_NONE  = 2'd3
  } clcs_action_e;

  typedef enum logic [1:0] {
    SEQ_INIT,
    SEQ_DATA,
    SEQ_NEWLINE,
    SEQ_SHUT
  } clcs_seq_e;

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] char_code;
  } clcs_in_t;

  typedef struct packed {
    logic        register_select;
    logic [7:0]  bus_byte;
    logic        wait_busy;
    logic [10:0] settle_us;
    logic        last;
  } clcs_out_t;

  localparam logic [1:0]  MODE_ONE_ROW   = 2'd1;
  localparam logic [1:0]  MODE_TWO_ROWS  = 2'd2;
  localparam logic [7:0]  CHAR_NEWLINE   = 8'd10;

  localparam logic [7:0]  CMD_FUNC_SET   = 8'h30;
  localparam logic [7:0]  CMD_DISP_ON    = 8'h0E;
  localparam logic [7:0]  CMD_DISP_OFF   = 8'h08;
  localparam logic [7:0]  CMD_CLEAR      = 8'h01;
  localparam logic [7:0]  CMD_ENTRY      = 8'h04;
  localparam logic [7:0]  CMD_HOME       = 8'h80;
  localparam logic [7:0]  CMD_ROW_TWO    = 8'hC0;
  localparam logic [7:0]  FS_TWO_LINE    = 8'h08;
  localparam logic [7:0]  FS_LARGE_FONT  = 8'h04;

  localparam logic [10:0] T_CMD_US       = 11'd39;
  localparam logic [10:0] T_DATA_US      = 11'd43;
  localparam logic [10:0] T_CLEAR_US     = 11'd1530;
  localparam logic [10:0] T_NONE_US      = 11'd0;

  localparam int unsigned OP_IDX_W       = 3;

  // Index of the final operation of each sequence.
  function automatic logic [OP_IDX_W-1:0] clcs_last_idx(clcs_seq_e seq);
    logic [OP_IDX_W-1:0] r;
    unique case (seq)
      SEQ_INIT: r = OP_IDX_W'(4);
      SEQ_SHUT: r = OP_IDX_W'(3);
      default:  r = '0;
    endcase
    return r;
  endfunction

  function automatic clcs_out_t mk_op(logic rs, logic [7:0] b, logic busy,
                                      logic [10:0] settle, logic fin);
    clcs_out_t o;
    o.register_select = rs;
    o.bus_byte        = b;
    o.wait_busy       = busy;
    o.settle_us       = settle;
    o.last            = fin;
    return o;
  endfunction

  // arg is the function-set byte for init, the character for a data write.
  function automatic clcs_out_t clcs_op(clcs_seq_e seq, logic [OP_IDX_W-1:0] idx,
                                        logic [7:0] arg);
    clcs_out_t o;
    o = mk_op(1'b0, CMD_HOME, 1'b0, T_NONE_US, 1'b1);
    unique case (seq)
      SEQ_INIT: begin
        unique case (idx)
          3'd0:    o = mk_op(1'b0, arg,         1'b1, T_CMD_US,   1'b0);
          3'd1:    o = mk_op(1'b0, CMD_DISP_ON, 1'b1, T_CMD_US,   1'b0);
          3'd2:    o = mk_op(1'b0, CMD_CLEAR,   1'b1, T_CLEAR_US, 1'b0);
          3'd3:    o = mk_op(1'b0, CMD_ENTRY,   1'b1, T_CMD_US,   1'b0);
          default: o = mk_op(1'b0, CMD_HOME,    1'b0, T_NONE_US,  1'b1);
        endcase
      end
      SEQ_SHUT: begin
        unique case (idx)
          3'd0:    o = mk_op(1'b0, CMD_CLEAR,    1'b1, T_CLEAR_US, 1'b0);
          3'd1:    o = mk_op(1'b0, CMD_DISP_OFF, 1'b1, T_CMD_US,   1'b0);
          3'd2:    o = mk_op(1'b0, CMD_ENTRY,    1'b1, T_CMD_US,   1'b0);
          default: o = mk_op(1'b0, CMD_FUNC_SET, 1'b1, T_CMD_US,   1'b1);
        endcase
      end
      SEQ_NEWLINE: o = mk_op(1'b0, CMD_ROW_TWO, 1'b0, T_NONE_US, 1'b1);
      SEQ_DATA:    o = mk_op(1'b1, arg,         1'b1, T_DATA_US, 1'b1);
      default:     o = mk_op(1'b1, arg,         1'b1, T_DATA_US, 1'b1);
    endcase
    return o;
  endfunction

endpackage

/* hdl/char_lcd_command_sequencer_top.sv */
// Character-LCD command sequencer: turns driver requests into display bus operations.
// Each request yields one beat per bus operation, one beat a cycle while the output is
// not stalled: init gives five, shutdown four, a character write one, an unused action
// none. A request sits in the request register while its beats are issued from an
// operation counter into the output register; the next request is taken in the same
// cycle as the final beat of the current one is loaded, so the sustained request rate is set by
// the beat count of each request. Row state is updated when a request is taken.
// The display mode register may only be written while the sequencer is idle.
`include "char_lcd_command_sequencer_top_defines.svh"

module char_lcd_command_sequencer_top (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  clcs_pkg::clcs_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output clcs_pkg::clcs_out_t out_data_o,
  input  logic              cfg_we_i,
  input  logic [1:0]        cfg_data_i
);

  logic [1:0]                      mode_q;
  logic                            two_row_q, two_row_d;
  logic                            second_row_q, second_row_d;
  logic                            busy_q, busy_d;
  clcs_pkg::clcs_seq_e             seq_q, seq_d;
  logic [7:0]                      arg_q, arg_d;
  logic [clcs_pkg::OP_IDX_W-1:0]   idx_q, idx_d;
  logic                            out_valid_q, out_valid_d;
  clcs_pkg::clcs_out_t             out_q;

  logic                            in_acc;
  logic                            out_load;
  logic                            op_last;
  logic                            large_font;
  clcs_pkg::clcs_out_t             op;

  assign op       = clcs_pkg::clcs_op(seq_q, idx_q, arg_q);
  assign op_last  = (idx_q == clcs_pkg::clcs_last_idx(seq_q));
  assign out_load = busy_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = busy_q && !(out_load && op_last);
  assign in_acc   = in_valid_i && !in_stall_o;

  assign large_font = !(mode_q == clcs_pkg::MODE_ONE_ROW ||
                        mode_q == clcs_pkg::MODE_TWO_ROWS);

  always_comb begin
    busy_d       = busy_q;
    seq_d        = seq_q;
    arg_d        = arg_q;
    idx_d        = idx_q;
    two_row_d    = two_row_q;
    second_row_d = second_row_q;
    if (out_load) begin
      idx_d = idx_q + 1'b1;
      if (op_last) begin
        busy_d = 1'b0;
      end
    end
    if (in_acc) begin
      idx_d = '0;
      unique case (clcs_pkg::clcs_action_e'(in_data_i.action))
        clcs_pkg::ACT_INIT: begin
          busy_d       = 1'b1;
          seq_d        = clcs_pkg::SEQ_INIT;
          two_row_d    = (mode_q == clcs_pkg::MODE_TWO_ROWS);
          second_row_d = 1'b0;
          arg_d        = clcs_pkg::CMD_FUNC_SET
                         | (two_row_d ? clcs_pkg::FS_TWO_LINE : 8'h00)
                         | (large_font ? clcs_pkg::FS_LARGE_FONT : 8'h00);
        end
        clcs_pkg::ACT_WRITE: begin
          busy_d = 1'b1;
          arg_d  = in_data_i.char_code;
          if (in_data_i.char_code == clcs_pkg::CHAR_NEWLINE && two_row_q && !second_row_q) begin
            seq_d        = clcs_pkg::SEQ_NEWLINE;
            second_row_d = 1'b1;
          end else begin
            seq_d = clcs_pkg::SEQ_DATA;
          end
        end
        clcs_pkg::ACT_SHUT: begin
          busy_d       = 1'b1;
          seq_d        = clcs_pkg::SEQ_SHUT;
          two_row_d    = 1'b0;
          second_row_d = 1'b0;
        end
        default: begin
          // unused action: swallowed, nothing issued
        end
      endcase
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q       <= '0;
      two_row_q    <= 1'b0;
      second_row_q <= 1'b0;
      busy_q       <= 1'b0;
      seq_q        <= clcs_pkg::SEQ_DATA;
      idx_q        <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        mode_q <= cfg_data_i;
      end
      two_row_q    <= two_row_d;
      second_row_q <= second_row_d;
      busy_q       <= busy_d;
      seq_q        <= seq_d;
      idx_q        <= idx_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    arg_q <= arg_d;
    if (out_load) begin
      out_q <= op;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `CLCS_ASSERT(a_idle_takes, !busy_q, !in_stall_o, "idle sequencer stalls its input")
  `CLCS_ASSERT(a_row_flags, second_row_q, two_row_q, "second row marked outside two-row mode")
  `CLCS_ASSERT(a_idx_range, busy_q, idx_q <= clcs_pkg::clcs_last_idx(seq_q), "op index overran")
  `CLCS_ASSERT_NEXT(a_last_frees, out_load && op_last && !in_acc, !busy_q, "busy after last beat")

endmodule
